@@ sv/dpr_pkg.sv @@
// shared types, constants and reset values for the depth pixel to registered point unit
`default_nettype none
package dpr_pkg;

   localparam int PIXEL_BITS     = 11;
   localparam int DEPTH_BITS     = 16;
   localparam int COORD_BITS     = 32;
   localparam int ZVAL_BITS      = 19;
   localparam int Z_BITS         = 28;
   localparam int PIX_OUT_BITS   = 16;
   localparam int TERM_BITS      = 50;
   localparam int QBITS          = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // floor(n / 125) by reciprocal, one correction step afterwards
   localparam int           DIV_125       = 125;
   localparam logic [33:0]  RECIP_125_X   = 34'd8796093022;   // floor(2^40 / 125)
   localparam logic [25:0]  RECIP_125_Z   = 26'd34359738;     // floor(2^32 / 125)

   localparam logic signed [PIX_OUT_BITS-1:0] PIX_MAX = 16'sh7fff;
   localparam logic signed [PIX_OUT_BITS-1:0] PIX_MIN = 16'sh8000;

   localparam logic [15:0] RST_CENTER_X  = 16'd5112;
   localparam logic [15:0] RST_CENTER_Y  = 16'd3832;
   localparam logic [31:0] RST_INV_FOC_X = 32'd8181025;
   localparam logic [31:0] RST_INV_FOC_Y = 32'd8181025;
   localparam logic [63:0] RST_ROW_U     = 64'd43980465127840;
   localparam logic [63:0] RST_ROW_V     = 64'd32986449838080;
   localparam logic [63:0] RST_ROW_W     = 64'd137438953472;
   localparam logic [31:0] RST_BOUNDS    = 32'd31457920;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_INV_FOC_X = 3'd2,
      CSR_INV_FOC_Y = 3'd3,
      CSR_ROW_U     = 3'd4,
      CSR_ROW_V     = 3'd5,
      CSR_ROW_W     = 3'd6,
      CSR_BOUNDS    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [31:0] inv_focal_x;
      logic [31:0] inv_focal_y;
      logic [63:0] row_u;
      logic [63:0] row_v;
      logic [63:0] row_w;
      logic [31:0] bounds;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] col;
      logic [PIXEL_BITS-1:0] row;
      logic [DEPTH_BITS-1:0] depth;
   } pixel_type;

   typedef struct packed {
      logic                         valid;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [ZVAL_BITS-1:0]         z;
   } point_type;

   typedef struct packed {
      point_type                   pt;
      logic signed [TERM_BITS-1:0] tu;
      logic signed [TERM_BITS-1:0] tv;
      logic signed [TERM_BITS-1:0] tw;
   } term_type;

   typedef struct packed {
      logic                           point_valid;
      logic signed [COORD_BITS-1:0]   point_x;
      logic signed [COORD_BITS-1:0]   point_y;
      logic [Z_BITS-1:0]              point_z;
      logic signed [PIX_OUT_BITS-1:0] colour_col;
      logic signed [PIX_OUT_BITS-1:0] colour_row;
      logic                           in_colour_image;
   } result_type;

endpackage
`default_nettype wire

@@ sv/dpr_csr.sv @@
// configuration register file
`default_nettype none
module dpr_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dpr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dpr_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output dpr_pkg::cfg_type                          cfg
);
   import dpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:  cfg_in.center_x    = csr_data[15:0];
            CSR_CENTER_Y:  cfg_in.center_y    = csr_data[15:0];
            CSR_INV_FOC_X: cfg_in.inv_focal_x = csr_data[31:0];
            CSR_INV_FOC_Y: cfg_in.inv_focal_y = csr_data[31:0];
            CSR_ROW_U:     cfg_in.row_u       = csr_data;
            CSR_ROW_V:     cfg_in.row_v       = csr_data;
            CSR_ROW_W:     cfg_in.row_w       = csr_data;
            CSR_BOUNDS:    cfg_in.bounds      = csr_data[31:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= RST_CENTER_X;
         cfg_ff.center_y    <= RST_CENTER_Y;
         cfg_ff.inv_focal_x <= RST_INV_FOC_X;
         cfg_ff.inv_focal_y <= RST_INV_FOC_Y;
         cfg_ff.row_u       <= RST_ROW_U;
         cfg_ff.row_v       <= RST_ROW_V;
         cfg_ff.row_w       <= RST_ROW_W;
         cfg_ff.bounds      <= RST_BOUNDS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/dpr_backproj.sv @@
// back-projection pipeline: pixel and depth to camera-frame point
`default_nettype none
module dpr_backproj (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dpr_pkg::cfg_type    cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire dpr_pkg::pixel_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dpr_pkg::point_type       out_data
);
   import dpr_pkg::*;

   localparam int STAGES = 6;

   typedef struct packed {
      logic        valid;
      logic        negx;
      logic        negy;
      logic [15:0] magx;
      logic [15:0] magy;
      logic [15:0] depth;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic        negx;
      logic        negy;
      logic [47:0] px;
      logic [47:0] py;
      logic [18:0] zest;
      logic [15:0] depth;
   } s2_type;

   typedef struct packed {
      logic        valid;
      logic        negx;
      logic        negy;
      logic [47:0] ax;
      logic [47:0] ay;
      logic [18:0] z;
   } s3_type;

   typedef struct packed {
      logic        valid;
      logic        negx;
      logic        negy;
      logic [36:0] nx;
      logic [36:0] ny;
      logic [52:0] lox;
      logic [51:0] hix;
      logic [52:0] loy;
      logic [51:0] hiy;
      logic [18:0] z;
   } s4_type;

   typedef struct packed {
      logic        valid;
      logic        negx;
      logic        negy;
      logic [36:0] nx;
      logic [36:0] ny;
      logic [30:0] qx;
      logic [30:0] qy;
      logic [18:0] z;
   } s5_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   rdy;

   s1_type    s1_ff, s1_in;
   s2_type    s2_ff, s2_in;
   s3_type    s3_ff, s3_in;
   s4_type    s4_ff, s4_in;
   s5_type    s5_ff, s5_in;
   point_type s6_ff, s6_in;

   // stall chain: a stage loads when empty or when the next one moves
   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = s6_ff;

   // offset from principal point, sign and magnitude
   logic [16:0] dxx, dyy, magx_w, magy_w;
   always_comb begin
      dxx = {2'b00, in_data.col, 4'b0000} - {1'b0, cfg.center_x};
      dyy = {2'b00, in_data.row, 4'b0000} - {1'b0, cfg.center_y};
      magx_w = dxx[16] ? (17'd0 - dxx) : dxx;
      magy_w = dyy[16] ? (17'd0 - dyy) : dyy;
      s1_in.valid = in_data.depth != '0;
      s1_in.negx  = dxx[16];
      s1_in.negy  = dyy[16];
      s1_in.magx  = magx_w[15:0];
      s1_in.magy  = magy_w[15:0];
      s1_in.depth = in_data.depth;
   end

   // scale by reciprocal focal length, estimate z
   logic [24:0] zn2;
   logic [50:0] zprod;
   always_comb begin
      zn2         = {s1_ff.depth, 9'b0};
      zprod       = 51'(zn2) * 51'(RECIP_125_Z);
      s2_in.valid = s1_ff.valid;
      s2_in.negx  = s1_ff.negx;
      s2_in.negy  = s1_ff.negy;
      s2_in.px    = 48'(s1_ff.magx) * 48'(cfg.inv_focal_x);
      s2_in.py    = 48'(s1_ff.magy) * 48'(cfg.inv_focal_y);
      s2_in.zest  = zprod[50:32];
      s2_in.depth = s1_ff.depth;
   end

   // times depth, finish z
   logic [25:0] zn3, zmul, zrem;
   always_comb begin
      zn3         = {1'b0, s2_ff.depth, 9'b0};
      zmul        = 26'(s2_ff.zest) * 26'(DIV_125);
      zrem        = zn3 - zmul;
      s3_in.valid = s2_ff.valid;
      s3_in.negx  = s2_ff.negx;
      s3_in.negy  = s2_ff.negy;
      s3_in.ax    = 48'(s2_ff.px[47:16]) * 48'(s2_ff.depth);
      s3_in.ay    = 48'(s2_ff.py[47:16]) * 48'(s2_ff.depth);
      s3_in.z     = (zrem >= 26'(DIV_125)) ? s2_ff.zest + 19'd1 : s2_ff.zest;
   end

   // divide by 2^11 then by 125: partial products of the reciprocal
   always_comb begin
      s4_in.valid = s3_ff.valid;
      s4_in.negx  = s3_ff.negx;
      s4_in.negy  = s3_ff.negy;
      s4_in.nx    = s3_ff.ax[47:11];
      s4_in.ny    = s3_ff.ay[47:11];
      s4_in.lox   = 53'(s3_ff.ax[29:11]) * 53'(RECIP_125_X);
      s4_in.hix   = 52'(s3_ff.ax[47:30]) * 52'(RECIP_125_X);
      s4_in.loy   = 53'(s3_ff.ay[29:11]) * 53'(RECIP_125_X);
      s4_in.hiy   = 52'(s3_ff.ay[47:30]) * 52'(RECIP_125_X);
      s4_in.z     = s3_ff.z;
   end

   logic [70:0] sumx, sumy;
   always_comb begin
      sumx        = 71'(s4_ff.lox) + {s4_ff.hix, 19'b0};
      sumy        = 71'(s4_ff.loy) + {s4_ff.hiy, 19'b0};
      s5_in.valid = s4_ff.valid;
      s5_in.negx  = s4_ff.negx;
      s5_in.negy  = s4_ff.negy;
      s5_in.nx    = s4_ff.nx;
      s5_in.ny    = s4_ff.ny;
      s5_in.qx    = sumx[70:40];
      s5_in.qy    = sumy[70:40];
      s5_in.z     = s4_ff.z;
   end

   // correct the estimate by one and apply the sign
   logic [37:0] remx, remy;
   logic [30:0] qxf, qyf;
   logic [31:0] mx, my;
   always_comb begin
      remx    = 38'(s5_ff.nx) - 38'(s5_ff.qx) * 38'(DIV_125);
      remy    = 38'(s5_ff.ny) - 38'(s5_ff.qy) * 38'(DIV_125);
      qxf     = (remx >= 38'(DIV_125)) ? s5_ff.qx + 31'd1 : s5_ff.qx;
      qyf     = (remy >= 38'(DIV_125)) ? s5_ff.qy + 31'd1 : s5_ff.qy;
      mx      = {1'b0, qxf};
      my      = {1'b0, qyf};
      s6_in.valid = s5_ff.valid;
      s6_in.x     = s5_ff.negx ? -mx : mx;
      s6_in.y     = s5_ff.negy ? -my : my;
      s6_in.z     = s5_ff.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) s1_ff <= s1_in;
      if (rdy[1]) s2_ff <= s2_in;
      if (rdy[2]) s3_ff <= s3_in;
      if (rdy[3]) s4_ff <= s4_in;
      if (rdy[4]) s5_ff <= s5_in;
      if (rdy[5]) s6_ff <= s6_in;
   end

endmodule
`default_nettype wire

@@ sv/dpr_project.sv @@
// colour-camera matrix times homogeneous point, three terms
`default_nettype none
module dpr_project (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dpr_pkg::cfg_type    cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire dpr_pkg::point_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dpr_pkg::term_type        out_data
);
   import dpr_pkg::*;

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   rdy;

   logic signed [15:0] coef [3][4];

   point_type          pt1_ff, pt2_ff;
   logic signed [47:0] mx1_ff [3], mx1_in [3];
   logic signed [47:0] my1_ff [3], my1_in [3];
   logic signed [35:0] mz1_ff [3], mz1_in [3];
   logic signed [27:0] mk1_ff [3], mk1_in [3];
   logic signed [48:0] sa2_ff [3], sa2_in [3];
   logic signed [36:0] sb2_ff [3], sb2_in [3];
   term_type           out_ff, out_in;
   logic signed [19:0] zs;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = out_ff;

   // coefficient k sits in bits 16k+15..16k of each row
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         coef[0][k] = cfg.row_u[16*k +: 16];
         coef[1][k] = cfg.row_v[16*k +: 16];
         coef[2][k] = cfg.row_w[16*k +: 16];
      end
   end

   always_comb begin
      zs = $signed({1'b0, in_data.z});
      for (int r = 0; r < 3; r++) begin
         mx1_in[r] = coef[r][0] * in_data.x;
         my1_in[r] = coef[r][1] * in_data.y;
         mz1_in[r] = coef[r][2] * zs;
         mk1_in[r] = {coef[r][3], 12'b0};
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sa2_in[r] = 49'(mx1_ff[r]) + 49'(my1_ff[r]);
         sb2_in[r] = 37'(mz1_ff[r]) + 37'(mk1_ff[r]);
      end
   end

   always_comb begin
      out_in.pt = pt2_ff;
      out_in.tu = 50'(sa2_ff[0]) + 50'(sb2_ff[0]);
      out_in.tv = 50'(sa2_ff[1]) + 50'(sb2_ff[1]);
      out_in.tw = 50'(sa2_ff[2]) + 50'(sb2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pt1_ff <= in_data;
         for (int r = 0; r < 3; r++) begin
            mx1_ff[r] <= mx1_in[r];
            my1_ff[r] <= my1_in[r];
            mz1_ff[r] <= mz1_in[r];
            mk1_ff[r] <= mk1_in[r];
         end
      end
      if (rdy[1]) begin
         pt2_ff <= pt1_ff;
         for (int r = 0; r < 3; r++) begin
            sa2_ff[r] <= sa2_in[r];
            sb2_ff[r] <= sb2_in[r];
         end
      end
      if (rdy[2]) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/dpr_divide.sv @@
// pipelined restoring divider, saturation and bound test
`default_nettype none
module dpr_divide (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dpr_pkg::cfg_type    cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire dpr_pkg::term_type   in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output dpr_pkg::result_type      out_data
);
   import dpr_pkg::*;

   localparam int STAGES = QBITS + 3;
   localparam int WIDE   = TERM_BITS + QBITS;

   typedef struct packed {
      point_type             pt;
      logic                  neg_u;
      logic                  neg_v;
      logic                  wzero;
      logic [TERM_BITS-1:0]  mag_u;
      logic [TERM_BITS-1:0]  mag_v;
      logic [TERM_BITS-1:0]  mag_w;
   } abs_type;

   typedef struct packed {
      point_type             pt;
      logic                  neg_u;
      logic                  neg_v;
      logic                  wzero;
      logic                  ovf_u;
      logic                  ovf_v;
      logic [TERM_BITS-1:0]  divisor;
      logic [TERM_BITS-1:0]  rem_u;
      logic [TERM_BITS-1:0]  rem_v;
      logic [QBITS-1:0]      q_u;
      logic [QBITS-1:0]      q_v;
   } div_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES:0]   rdy;

   abs_type    a_ff, a_in;
   div_type    dst_ff [QBITS+1];
   div_type    dst_in [QBITS+1];
   result_type out_ff, out_in;

   always_comb begin
      rdy[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = out_ff;

   // signs and magnitudes; quotient truncates toward zero
   always_comb begin
      a_in.pt    = in_data.pt;
      a_in.neg_u = in_data.tu[TERM_BITS-1] ^ in_data.tw[TERM_BITS-1];
      a_in.neg_v = in_data.tv[TERM_BITS-1] ^ in_data.tw[TERM_BITS-1];
      a_in.wzero = in_data.tw == '0;
      a_in.mag_u = in_data.tu[TERM_BITS-1] ? TERM_BITS'(-in_data.tu) : TERM_BITS'(in_data.tu);
      a_in.mag_v = in_data.tv[TERM_BITS-1] ? TERM_BITS'(-in_data.tv) : TERM_BITS'(in_data.tv);
      a_in.mag_w = in_data.tw[TERM_BITS-1] ? TERM_BITS'(-in_data.tw) : TERM_BITS'(in_data.tw);
   end

   // quotients of 2^QBITS or more only saturate, so they are flagged up front
   logic [WIDE-1:0] dsh;
   always_comb begin
      dst_in[0].pt      = a_ff.pt;
      dst_in[0].neg_u   = a_ff.neg_u;
      dst_in[0].neg_v   = a_ff.neg_v;
      dst_in[0].wzero   = a_ff.wzero;
      dst_in[0].ovf_u   = WIDE'(a_ff.mag_u) >= {a_ff.mag_w, {QBITS{1'b0}}};
      dst_in[0].ovf_v   = WIDE'(a_ff.mag_v) >= {a_ff.mag_w, {QBITS{1'b0}}};
      dst_in[0].divisor = a_ff.mag_w;
      dst_in[0].rem_u   = a_ff.mag_u;
      dst_in[0].rem_v   = a_ff.mag_v;
      dst_in[0].q_u     = '0;
      dst_in[0].q_v     = '0;
      dsh               = '0;
      // one quotient bit per stage, most significant first
      for (int k = 1; k <= QBITS; k++) begin
         dst_in[k] = dst_ff[k-1];
         dsh = WIDE'(dst_ff[k-1].divisor) << (QBITS - k);
         if (WIDE'(dst_ff[k-1].rem_u) >= dsh) begin
            dst_in[k].rem_u = dst_ff[k-1].rem_u - dsh[TERM_BITS-1:0];
            dst_in[k].q_u   = {dst_ff[k-1].q_u[QBITS-2:0], 1'b1};
         end else begin
            dst_in[k].q_u   = {dst_ff[k-1].q_u[QBITS-2:0], 1'b0};
         end
         if (WIDE'(dst_ff[k-1].rem_v) >= dsh) begin
            dst_in[k].rem_v = dst_ff[k-1].rem_v - dsh[TERM_BITS-1:0];
            dst_in[k].q_v   = {dst_ff[k-1].q_v[QBITS-2:0], 1'b1};
         end else begin
            dst_in[k].q_v   = {dst_ff[k-1].q_v[QBITS-2:0], 1'b0};
         end
      end
   end

   div_type                        fin;
   logic signed [QBITS:0]          qs_u, qs_v;
   logic signed [PIX_OUT_BITS-1:0] sat_u, sat_v;
   logic                           in_u, in_v, proj_ok;
   logic [15:0]                    width, height;
   always_comb begin
      fin     = dst_ff[QBITS];
      width   = cfg.bounds[15:0];
      height  = cfg.bounds[31:16];
      qs_u    = fin.neg_u ? -$signed({1'b0, fin.q_u}) : $signed({1'b0, fin.q_u});
      qs_v    = fin.neg_v ? -$signed({1'b0, fin.q_v}) : $signed({1'b0, fin.q_v});

      if (fin.ovf_u) begin
         sat_u = fin.neg_u ? PIX_MIN : PIX_MAX;
      end else if (qs_u > (QBITS+1)'(PIX_MAX)) begin
         sat_u = PIX_MAX;
      end else if (qs_u < (QBITS+1)'(PIX_MIN)) begin
         sat_u = PIX_MIN;
      end else begin
         sat_u = qs_u[PIX_OUT_BITS-1:0];
      end

      if (fin.ovf_v) begin
         sat_v = fin.neg_v ? PIX_MIN : PIX_MAX;
      end else if (qs_v > (QBITS+1)'(PIX_MAX)) begin
         sat_v = PIX_MAX;
      end else if (qs_v < (QBITS+1)'(PIX_MIN)) begin
         sat_v = PIX_MIN;
      end else begin
         sat_v = qs_v[PIX_OUT_BITS-1:0];
      end

      in_u    = !fin.ovf_u && !qs_u[QBITS] && (qs_u[QBITS-1:0] < {1'b0, width});
      in_v    = !fin.ovf_v && !qs_v[QBITS] && (qs_v[QBITS-1:0] < {1'b0, height});
      proj_ok = fin.pt.valid && !fin.wzero;

      out_in.point_valid     = fin.pt.valid;
      out_in.point_x         = fin.pt.valid ? fin.pt.x : '0;
      out_in.point_y         = fin.pt.valid ? fin.pt.y : '0;
      out_in.point_z         = fin.pt.valid ? Z_BITS'(fin.pt.z) : '0;
      out_in.colour_col      = proj_ok ? sat_u : '0;
      out_in.colour_row      = proj_ok ? sat_v : '0;
      out_in.in_colour_image = proj_ok && in_u && in_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_ff <= a_in;
      end
      for (int j = 0; j <= QBITS; j++) begin
         if (rdy[j+1]) begin
            dst_ff[j] <= dst_in[j];
         end
      end
      if (rdy[STAGES-1]) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/depth_pixel_to_registered_point_unit.sv @@
// top level: depth pixel to camera-frame point and registered colour pixel
//
// req_ stream: one depth pixel per transaction (column, row, depth in mm)
// rsp_ stream: one result per pixel, in order: the camera-frame point in
//   metres as Q.12, the projected colour pixel and two flags in rsp_tuser
// csr_ port: register index and data; a write completes on csr_valid as
//   csr_ready is always high; write only while the pipeline is empty
// latency: 29 cycles from req_ transaction to rsp_tvalid with no stall
//   (6 back-projection stages, 3 matrix stages, 20 divider stages)
// throughput: one pixel per cycle; the 17-stage restoring divider, one
//   quotient bit per stage, sets the depth
// stall: every stage holds its own valid bit and loads when empty or when
//   its successor moves, so bubbles close up and the block keeps taking
//   pixels while a result waits at the output register
// reset: empties the pipeline and loads the default camera registers
`default_nettype none
module depth_pixel_to_registered_point_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: pixel_col[10:0], pixel_row[21:11], depth_mm[37:22], zero pad
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [39:0]                         req_tdata,
   // rsp_tdata: point_x[31:0], point_y[63:32], point_z[91:64],
   //            colour_col[107:92], colour_row[123:108], zero pad
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [127:0]                             rsp_tdata,
   // rsp_tuser: point_valid[0], in_colour_image[1]
   output logic [1:0]                               rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dpr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dpr_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import dpr_pkg::*;

   cfg_type    cfg;
   pixel_type  pix;
   point_type  bp_data;
   term_type   pj_data;
   result_type res;
   logic       bp_valid, bp_ready;
   logic       pj_valid, pj_ready;

   // unpack the request transaction
   assign pix.col   = req_tdata[10:0];
   assign pix.row   = req_tdata[21:11];
   assign pix.depth = req_tdata[37:22];

   dpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // pinhole back-projection
   dpr_backproj u_backproj (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pix),
      .out_valid (bp_valid),
      .out_ready (bp_ready),
      .out_data  (bp_data)
   );

   // 3x4 colour matrix
   dpr_project u_project (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (bp_valid),
      .in_ready  (bp_ready),
      .in_data   (bp_data),
      .out_valid (pj_valid),
      .out_ready (pj_ready),
      .out_data  (pj_data)
   );

   // perspective divide, saturation, bound test; last stage is the output register
   dpr_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (pj_valid),
      .in_ready  (pj_ready),
      .in_data   (pj_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // pack the response transaction
   assign rsp_tdata = {4'b0000, res.colour_row, res.colour_col, res.point_z,
                       res.point_y, res.point_x};
   assign rsp_tuser = {res.in_colour_image, res.point_valid};

endmodule
`default_nettype wire
